// File: rtl/gffbc_pkg.sv
package gffbc_pkg;

   localparam int MAX_ATOMS_DEFAULT = 64;
   localparam int MAX_BINS_DEFAULT  = 64;

   localparam logic [6:0] ATOM_COUNT_RESET = 7'd64;

   typedef struct packed {
      logic        start_set;
      logic [63:0] neighbor_mask;
   } req_type;

   typedef struct packed {
      logic [5:0] atom_index;
      logic [5:0] bin_index;
      logic [6:0] bins_in_use;
      logic       overflow;
      logic       last_atom;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic check;
      logic update;
      logic clear;
   } cell_ctl_type;

endpackage

// File: rtl/gffbc_cell.sv
module gffbc_cell #(
   parameter int WIDTH = gffbc_pkg::MAX_ATOMS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gffbc_pkg::cell_ctl_type ctl,
   input  logic [WIDTH-1:0]       mask,
   input  logic [WIDTH-1:0]       atom_bit,
   input  logic                   taken_in,
   output logic                   taken_out,
   output logic                   claim
);

   logic [WIDTH-1:0] members_ff;
   logic [WIDTH-1:0] members_in;
   logic             fit_ff;
   logic             fit_in;

   // a bin fits when it holds none of the masked neighbors
   assign fit_in    = ctl.check ? ~|(members_ff & mask) : fit_ff;
   assign claim     = fit_ff & ~taken_in;
   assign taken_out = taken_in | fit_ff;

   always_comb begin
      if (ctl.clear) begin
         members_in = '0;
      end else if (ctl.update && claim) begin
         members_in = members_ff | atom_bit;
      end else begin
         members_in = members_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         members_ff <= '0;
         fit_ff     <= 1'b0;
      end else begin
         members_ff <= members_in;
         fit_ff     <= fit_in;
      end
   end

endmodule

// File: rtl/greedy_first_fit_bin_coloring_top.sv
// a request goes from the bin check state to the place state, and the result is registered on place
// requests pass one at a time through the check/place loop over the bin cells;
// a new request is taken in the place cycle when the result register is free
// reset (synchronous): all bins empty, no bins open, atom numbering at zero,
// atom_count back to 64
module greedy_first_fit_bin_coloring_top #(
   parameter int MAX_ATOMS = gffbc_pkg::MAX_ATOMS_DEFAULT,
   parameter int MAX_BINS  = gffbc_pkg::MAX_BINS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gffbc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gffbc_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int BW = $clog2(MAX_BINS);
   localparam int OW = $clog2(MAX_BINS + 1);

   gffbc_pkg::state_type    state_ff;
   gffbc_pkg::state_type    state_in;
   gffbc_pkg::cell_ctl_type ctl;

   logic [6:0]           atom_count_ff;
   logic [6:0]           atom_count_in;
   logic [AW-1:0]        next_atom_ff;
   logic [AW-1:0]        next_atom_in;
   logic [AW-1:0]        next_atom_upd;
   logic [OW-1:0]        open_bins_ff;
   logic [OW-1:0]        open_bins_in;
   logic [OW-1:0]        open_bins_upd;
   logic [OW-1:0]        open_bins_new;
   logic [AW-1:0]        atom_ff;
   logic [AW-1:0]        atom_in;
   logic [MAX_ATOMS-1:0] mask_ff;
   logic [MAX_ATOMS-1:0] mask_in;
   logic [MAX_ATOMS-1:0] atom_bit;
   logic [MAX_ATOMS-1:0] new_bit;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   gffbc_pkg::rsp_type   rsp_ff;
   gffbc_pkg::rsp_type   rsp_in;

   logic [MAX_BINS:0]    taken;
   logic [MAX_BINS-1:0]  claim;
   logic [BW-1:0]        chosen;
   logic                 overflow;
   logic                 last;
   logic [6:0]           eff_count;
   logic                 out_free;
   logic                 do_update;
   logic                 req_accept;
   logic                 start;

   assign csr_ready = 1'b1;
   assign atom_count_in = (csr_valid && csr_ready) ? csr_data : atom_count_ff;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign do_update  = (state_ff == gffbc_pkg::ST_UPDATE) && out_free;
   assign req_stall  = ~((state_ff == gffbc_pkg::ST_IDLE) || do_update);
   assign req_accept = req_valid & ~req_stall;
   assign start      = req_accept & req_data.start_set;

   always_comb begin
      ctl.check  = (state_ff == gffbc_pkg::ST_CHECK);
      ctl.update = do_update;
      ctl.clear  = start | (do_update & last);
   end

   assign atom_bit = {{(MAX_ATOMS-1){1'b0}}, 1'b1} << atom_ff;

   // chain of bin cells, the first fitting bin claims the atom
   assign taken[0] = 1'b0;
   for (genvar i = 0; i < MAX_BINS; i++) begin : g_bin
      gffbc_cell #(
         .WIDTH(MAX_ATOMS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .mask     (mask_ff),
         .atom_bit (atom_bit),
         .taken_in (taken[i]),
         .taken_out(taken[i+1]),
         .claim    (claim[i])
      );
   end

   assign overflow = ~taken[MAX_BINS];

   always_comb begin
      chosen = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
         if (claim[i]) begin
            chosen = chosen | BW'(i);
         end
      end
   end

   always_comb begin
      if (atom_count_ff != 7'd0 && atom_count_ff <= 7'(MAX_ATOMS)) begin
         eff_count = atom_count_ff;
      end else begin
         eff_count = 7'(MAX_ATOMS);
      end
   end

   assign last = ((7'(atom_ff) + 7'd1) == eff_count) || (atom_ff == AW'(MAX_ATOMS - 1));

   always_comb begin
      if (!overflow && (OW'(chosen) == open_bins_ff)) begin
         open_bins_new = open_bins_ff + OW'(1);
      end else begin
         open_bins_new = open_bins_ff;
      end
   end

   always_comb begin
      next_atom_upd = next_atom_ff;
      open_bins_upd = open_bins_ff;
      if (do_update) begin
         next_atom_upd = last ? '0 : atom_ff + AW'(1);
         open_bins_upd = last ? '0 : open_bins_new;
      end
      next_atom_in = start ? '0 : next_atom_upd;
      open_bins_in = start ? '0 : open_bins_upd;
   end

   assign new_bit = {{(MAX_ATOMS-1){1'b0}}, 1'b1} << next_atom_in;

   always_comb begin
      atom_in = atom_ff;
      mask_in = mask_ff;
      if (req_accept) begin
         atom_in = next_atom_in;
         mask_in = req_data.neighbor_mask[MAX_ATOMS-1:0] & (new_bit - MAX_ATOMS'(1));
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (do_update) begin
         rsp_in.atom_index  = 6'(atom_ff);
         rsp_in.bin_index   = overflow ? 6'd0 : 6'(chosen);
         rsp_in.bins_in_use = 7'(open_bins_new);
         rsp_in.overflow    = overflow;
         rsp_in.last_atom   = last;
      end
   end

   always_comb begin
      if (do_update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gffbc_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = gffbc_pkg::ST_CHECK;
            end
         end
         gffbc_pkg::ST_CHECK: begin
            state_in = gffbc_pkg::ST_UPDATE;
         end
         gffbc_pkg::ST_UPDATE: begin
            if (do_update) begin
               state_in = req_accept ? gffbc_pkg::ST_CHECK : gffbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gffbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gffbc_pkg::ST_IDLE;
         atom_count_ff <= gffbc_pkg::ATOM_COUNT_RESET;
         next_atom_ff  <= '0;
         open_bins_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         atom_count_ff <= atom_count_in;
         next_atom_ff  <= next_atom_in;
         open_bins_ff  <= open_bins_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      atom_ff <= atom_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_claim_onehot: assert property (@(posedge clock) disable iff (reset)
      do_update |-> $onehot0(claim))
      else $error("more than one bin claimed the atom");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (do_update && overflow) |-> (open_bins_ff == OW'(MAX_BINS)))
      else $error("overflow with free bins left");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (do_update && last) |=> (next_atom_ff == '0 && open_bins_ff == '0))
      else $error("set did not restart after last atom");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == gffbc_pkg::ST_CHECK))
      else $error("accepted request not checked next cycle");

endmodule
